>>> rtl/cle_pkg.sv
// Shared types, codes and sizes of the console line editor.
// Used by cle_ctrl, cle_dp and console_line_editor_core; no dependencies.
package cle_pkg;

  // Storage depth of one line and the widths derived from it.
  localparam int LINE_CAPACITY = 32;
  localparam int ADDR_W = (LINE_CAPACITY > 1) ? $clog2(LINE_CAPACITY) : 1;
  localparam int CNT_W = $clog2(LINE_CAPACITY + 1);

  // Field and register widths.
  localparam int CHAR_W = 7;
  localparam int BYTE_W = 8;
  localparam int STATUS_W = 3;
  localparam int LEN_W = 6;
  localparam int KIND_W = 2;
  localparam int LIMIT_W = 6;
  localparam int TIMEOUT_W = 24;
  localparam int TICK_W = 25;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_DATA_W = 24;
  localparam int OUT_DATA_W = 16;

  // Register indexes of the configuration port.
  localparam logic [CFG_IDX_W-1:0] CFG_LINE_LIMIT = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT = 1'd1;

  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 6'd32;
  localparam logic [TICK_W-1:0] TICK_MAX = {TICK_W{1'b1}};

  // Control characters.
  localparam logic [CHAR_W-1:0] CH_BS = 7'h08;
  localparam logic [CHAR_W-1:0] CH_NL = 7'h0A;
  localparam logic [CHAR_W-1:0] CH_CR = 7'h0D;
  localparam logic [CHAR_W-1:0] CH_NAK = 7'h15;
  localparam logic [CHAR_W-1:0] CH_DEL = 7'h7F;

  // Kind of a result item.
  typedef enum logic [KIND_W-1:0] {
    KIND_ECHO = 2'd0,
    KIND_LINE = 2'd1,
    KIND_END  = 2'd2
  } out_kind_t;

  // Line end status.
  typedef enum logic [STATUS_W-1:0] {
    ST_NONE     = 3'd0,
    ST_COMPLETE = 3'd1,
    ST_CANCEL   = 3'd2,
    ST_TOO_LONG = 3'd3,
    ST_TIMEOUT  = 3'd4
  } line_status_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic         latch_in;
    logic         tick_inc;
    logic         clear_armed;
    logic         fill_dec;
    logic         store_char;
    logic         rd_start;
    logic         rd_next;
    logic         load_echo;
    logic         load_line;
    logic         load_end;
    logic         end_line;
    line_status_t end_status;
  } cle_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic is_tick;
    logic is_bs;
    logic is_nl;
    logic is_cancel;
    logic armed;
    logic timeout_off;
    logic expired;
    logic full;
    logic fill_zero;
    logic rd_last;
    logic slot_free;
  } cle_stat_t;

endpackage

>>> rtl/console_line_editor_core.sv
// Console line editor, top level: wires the controller and the datapath.
// Flow: an accepted character item is latched, evaluated, and its echo loaded into the output
// register once the slot is free; a tick goes through evaluation and a tick check, and an
// expired timeout then loads its status. One item at a time; a line end reads the stored
// characters through the single read port of the line memory, one result per free slot.
// Reset: synchronous, active-low rst_n empties the line, arms the timeout, and restores
// line_limit 32 and timeout_ticks 0. The line memory is not cleared.
module console_line_editor_core (
  input  logic                           clk,
  input  logic                           rst_n,
  // Configuration write port.
  input  logic                           cfg_we,
  input  logic [cle_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [cle_pkg::CFG_DATA_W-1:0] cfg_wdata,
  // Input stream.
  input  logic                           in_tvalid,
  output logic                           in_tready,
  input  logic [7:0]                     in_tdata,   // [7:0] char_code
  input  logic                           in_tuser,   // [0] kind
  // Result stream.
  output logic                           out_tvalid,
  input  logic                           out_tready,
  output logic [cle_pkg::OUT_DATA_W-1:0] out_tdata,  // [6:0] out_char, [9:7] status,
                                                     // [15:10] line_length
  output logic [cle_pkg::KIND_W-1:0]     out_tuser,  // [1:0] out_kind
  output logic                           out_tlast   // last
);
  import cle_pkg::*;

  cle_cmd_t            cmd;
  cle_stat_t           stat;
  logic [CHAR_W-1:0]   out_char;
  logic [STATUS_W-1:0] out_status;
  logic [LEN_W-1:0]    out_len;

  // Sequencer.
  cle_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  // Storage, counters and the output register.
  cle_dp u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .in_char    (in_tdata),
    .in_kind    (in_tuser),
    .cmd        (cmd),
    .stat       (stat),
    .out_valid  (out_tvalid),
    .out_ready  (out_tready),
    .out_kind   (out_tuser),
    .out_char   (out_char),
    .out_status (out_status),
    .out_len    (out_len),
    .out_last   (out_tlast)
  );

  // Pack the result fields, first field in the lowest bits.
  assign out_tdata = {out_len, out_status, out_char};

endmodule

>>> rtl/cle_dp.sv
// Datapath of the console line editor: configuration registers, item latch,
// line memory, fill and tick counters, and the output register.
// Depends on cle_pkg; driven by cle_ctrl.
module cle_dp (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cfg_we,
  input  logic [cle_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [cle_pkg::CFG_DATA_W-1:0] cfg_wdata,
  input  logic [cle_pkg::BYTE_W-1:0]   in_char,
  input  logic                         in_kind,
  input  cle_pkg::cle_cmd_t            cmd,
  output cle_pkg::cle_stat_t           stat,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [cle_pkg::KIND_W-1:0]   out_kind,
  output logic [cle_pkg::CHAR_W-1:0]   out_char,
  output logic [cle_pkg::STATUS_W-1:0] out_status,
  output logic [cle_pkg::LEN_W-1:0]    out_len,
  output logic                         out_last
);
  import cle_pkg::*;

  logic [LIMIT_W-1:0]   limit_r;
  logic [TIMEOUT_W-1:0] timeout_r;
  logic                 kind_r;
  logic [CHAR_W-1:0]    char_r;
  logic [CHAR_W-1:0]    char_map;
  logic [CNT_W-1:0]     fill_r;
  logic [TICK_W-1:0]    tick_r;
  logic                 armed_r;
  logic [CNT_W-1:0]     rd_cnt_r;
  logic [CNT_W-1:0]     rd_cnt_inc;
  logic [ADDR_W-1:0]    rd_addr;
  logic [CHAR_W-1:0]    rd_data_r;
  logic [CHAR_W-1:0]    line_mem [LINE_CAPACITY];
  logic [LIMIT_W-1:0]   eff_limit;
  logic                 full;
  logic                 is_bs;
  logic                 is_nl;
  logic                 is_cancel;
  logic                 slot_free;
  logic                 out_valid_r;
  logic [KIND_W-1:0]    out_kind_r;
  logic [CHAR_W-1:0]    out_char_r;
  logic [STATUS_W-1:0]  out_status_r;
  logic [LEN_W-1:0]     out_len_r;
  logic                 out_last_r;

  // Configuration registers; to be written only while the block is idle, which the block does not enforce.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r   <= LIMIT_RESET;
      timeout_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_LINE_LIMIT: limit_r   <= cfg_wdata[LIMIT_W-1:0];
        CFG_TIMEOUT:    timeout_r <= cfg_wdata[TIMEOUT_W-1:0];
        default:        ;
      endcase
    end
  end

  // Mask to seven bits, fold carriage return and delete.
  always_comb begin
    char_map = in_char[CHAR_W-1:0];
    if (char_map == CH_CR) begin
      char_map = CH_NL;
    end
    if (char_map == CH_DEL) begin
      char_map = CH_BS;
    end
  end

  // Accepted item.
  always_ff @(posedge clk) begin
    if (cmd.latch_in) begin
      kind_r <= in_kind;
      char_r <= char_map;
    end
  end

  // Limit zero acts as one; a limit above the capacity acts as the capacity.
  always_comb begin
    eff_limit = limit_r;
    if (limit_r == '0) begin
      eff_limit = LIMIT_W'(1);
    end else if (limit_r > LIMIT_W'(LINE_CAPACITY)) begin
      eff_limit = LIMIT_W'(LINE_CAPACITY);
    end
  end

  assign full      = LIMIT_W'(fill_r) >= eff_limit;
  assign is_bs     = char_r == CH_BS;
  assign is_nl     = char_r == CH_NL;
  assign is_cancel = char_r == CH_NAK;
  assign slot_free = !out_valid_r || out_ready;

  // Fill count, tick count and timeout arming.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r  <= '0;
      tick_r  <= '0;
      armed_r <= 1'b1;
    end else begin
      if (cmd.end_line) begin
        fill_r  <= '0;
        tick_r  <= '0;
        armed_r <= 1'b1;
      end else begin
        if (cmd.clear_armed) begin
          armed_r <= 1'b0;
        end
        if (cmd.fill_dec && fill_r != '0) begin
          fill_r <= fill_r - 1'b1;
        end else if (cmd.store_char) begin
          fill_r <= fill_r + 1'b1;
        end
        if (cmd.tick_inc && tick_r != TICK_MAX) begin
          tick_r <= tick_r + 1'b1;
        end
      end
    end
  end

  // Line memory: one write port at the fill position, one registered read port.
  assign rd_cnt_inc = rd_cnt_r + 1'b1;
  assign rd_addr    = cmd.rd_start ? '0 : rd_cnt_inc[ADDR_W-1:0];

  always_ff @(posedge clk) begin
    if (cmd.store_char) begin
      line_mem[fill_r[ADDR_W-1:0]] <= char_r;
    end
    if (cmd.rd_start || cmd.rd_next) begin
      rd_data_r <= line_mem[rd_addr];
    end
  end

  // Readout position; rd_data_r always holds the entry at rd_cnt_r.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_cnt_r <= '0;
    end else if (cmd.rd_start) begin
      rd_cnt_r <= '0;
    end else if (cmd.rd_next) begin
      rd_cnt_r <= rd_cnt_inc;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.load_echo || cmd.load_line || cmd.load_end) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_echo) begin
      out_kind_r   <= KIND_ECHO;
      out_char_r   <= is_cancel ? CH_NL : char_r;
      out_status_r <= ST_NONE;
      out_len_r    <= '0;
      out_last_r   <= is_bs || (!is_nl && !is_cancel && !full);
    end else if (cmd.load_line) begin
      out_kind_r   <= KIND_LINE;
      out_char_r   <= rd_data_r;
      out_status_r <= ST_NONE;
      out_len_r    <= '0;
      out_last_r   <= 1'b0;
    end else if (cmd.load_end) begin
      out_kind_r   <= KIND_END;
      out_char_r   <= '0;
      out_status_r <= cmd.end_status;
      out_len_r    <= (cmd.end_status == ST_COMPLETE) ? LEN_W'(fill_r) : '0;
      out_last_r   <= 1'b1;
    end
  end

  assign out_valid  = out_valid_r;
  assign out_kind   = out_kind_r;
  assign out_char   = out_char_r;
  assign out_status = out_status_r;
  assign out_len    = out_len_r;
  assign out_last   = out_last_r;

  // Status toward the controller.
  always_comb begin
    stat.is_tick     = kind_r;
    stat.is_bs       = is_bs;
    stat.is_nl       = is_nl;
    stat.is_cancel   = is_cancel;
    stat.armed       = armed_r;
    stat.timeout_off = timeout_r == '0;
    stat.expired     = tick_r > TICK_W'(timeout_r);
    stat.full        = full;
    stat.fill_zero   = fill_r == '0;
    stat.rd_last     = rd_cnt_inc == fill_r;
    stat.slot_free   = slot_free;
  end

`ifndef SYNTHESIS
  // A new result never overwrites one that has not been taken.
  assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.load_echo || cmd.load_line || cmd.load_end) |-> slot_free)
    else $error("output register loaded while occupied");

  // Characters are stored only below the effective limit.
  assert property (@(posedge clk) disable iff (!rst_n)
    cmd.store_char |-> (LIMIT_W'(fill_r) < eff_limit))
    else $error("character stored into a full line");

  // A line end leaves an empty, armed line.
  assert property (@(posedge clk) disable iff (!rst_n)
    cmd.end_line |=> (fill_r == '0 && tick_r == '0 && armed_r))
    else $error("line end did not reset the line state");

  // The fill count stays within the line memory.
  assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= CNT_W'(LINE_CAPACITY))
    else $error("fill count beyond capacity");
`endif

endmodule

>>> rtl/cle_ctrl.sv
// Controller of the console line editor: sequences one item at a time and
// drives the datapath through command and status structs.
// Depends on cle_pkg.
module cle_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  cle_pkg::cle_stat_t stat,
  output cle_pkg::cle_cmd_t  cmd
);
  import cle_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EVAL,
    S_TICK_CHK,
    S_ECHO,
    S_LINE,
    S_END
  } state_t;

  state_t       state_r;
  state_t       state_nxt;
  line_status_t end_st_r;
  line_status_t end_st_nxt;

  assign in_ready = state_r == S_IDLE;

  // Next state and commands.
  always_comb begin
    state_nxt      = state_r;
    end_st_nxt     = end_st_r;
    cmd            = '0;
    cmd.end_status = end_st_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.latch_in = 1'b1;
          state_nxt    = S_EVAL;
        end
      end
      S_EVAL: begin
        if (!stat.is_tick) begin
          state_nxt = S_ECHO;
        end else if (!stat.armed || stat.timeout_off) begin
          state_nxt = S_IDLE;
        end else begin
          cmd.tick_inc = 1'b1;
          state_nxt    = S_TICK_CHK;
        end
      end
      S_TICK_CHK: begin
        if (stat.expired) begin
          end_st_nxt = ST_TIMEOUT;
          state_nxt  = S_END;
        end else begin
          state_nxt = S_IDLE;
        end
      end
      S_ECHO: begin
        if (stat.slot_free) begin
          cmd.load_echo   = 1'b1;
          cmd.clear_armed = 1'b1;
          if (stat.is_bs) begin
            cmd.fill_dec = 1'b1;
            state_nxt    = S_IDLE;
          end else if (stat.is_nl) begin
            end_st_nxt = ST_COMPLETE;
            if (stat.fill_zero) begin
              state_nxt = S_END;
            end else begin
              cmd.rd_start = 1'b1;
              state_nxt    = S_LINE;
            end
          end else if (stat.is_cancel) begin
            end_st_nxt = ST_CANCEL;
            state_nxt  = S_END;
          end else if (stat.full) begin
            end_st_nxt = ST_TOO_LONG;
            state_nxt  = S_END;
          end else begin
            cmd.store_char = 1'b1;
            state_nxt      = S_IDLE;
          end
        end
      end
      S_LINE: begin
        // One stored character per free output slot; the next read is issued
        // in the same cycle.
        if (stat.slot_free) begin
          cmd.load_line = 1'b1;
          cmd.rd_next   = 1'b1;
          if (stat.rd_last) begin
            state_nxt = S_END;
          end
        end
      end
      S_END: begin
        if (stat.slot_free) begin
          cmd.load_end = 1'b1;
          cmd.end_line = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // State and the pending line end status.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      end_st_r <= ST_NONE;
    end else begin
      state_r  <= state_nxt;
      end_st_r <= end_st_nxt;
    end
  end

`ifndef SYNTHESIS
  // At most one result is loaded per cycle.
  assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({cmd.load_echo, cmd.load_line, cmd.load_end}))
    else $error("several result loads in one cycle");

  // An item is taken only while no earlier item is at work, and an accepted item moves on to evaluation.
  assert property (@(posedge clk) disable iff (!rst_n)
    cmd.latch_in |=> (state_r == S_EVAL))
    else $error("accepted item not evaluated");

  // Every line end status item carries a real status.
  assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_end |-> (end_st_r != ST_NONE))
    else $error("line end without status");
`endif

endmodule
